// ===== sv/wsp_pkg.sv =====
// Shared types and constants of the wheel speed period meter.
// No dependencies; every other file of the block imports it.
package wsp_pkg;

    localparam int WINDOW_DEF  = 5;
    localparam int NUM_CH      = 3;
    localparam int CNT_W       = 32;
    localparam int SPD_W       = 16;
    localparam int STEP_W      = $clog2(SPD_W);
    localparam int TPR_W       = 8;
    localparam int SCALE_W     = 16;
    localparam int TMO_W       = 24;
    localparam int SPEED_UNITS = 10000;

    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_FRONT_TPR = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_REAR_TPR  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SCALE     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = 3'd4;

    localparam logic [TPR_W-1:0]   RST_FRONT_TPR = 8'd25;
    localparam logic [TPR_W-1:0]   RST_REAR_TPR  = 8'd100;
    localparam logic [SCALE_W-1:0] RST_SCALE     = 16'd28553;
    localparam logic [SPD_W-1:0]   RST_LIMIT     = 16'd15000;
    localparam logic [TMO_W-1:0]   RST_TIMEOUT   = 24'd500000;

    typedef enum logic [1:0] {
        CH_RIGHT,
        CH_LEFT,
        CH_REAR
    } t_chan;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_STORE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [TPR_W-1:0]   front_tpr;
        logic [TPR_W-1:0]   rear_tpr;
        logic [SCALE_W-1:0] speed_scale;
        logic [SPD_W-1:0]   speed_limit;
        logic [TMO_W-1:0]   stall_timeout;
    } t_cfg;

    typedef struct packed {
        logic  tick_en;
        logic  mul_en;
        logic  load_en;
        logic  step_en;
        logic  store_en;
        logic  finish;
        t_chan chan;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ===== sv/wsp_if.sv =====
// Valid/ready channel interfaces: sensor tick input and speed result output.
// Depends on wsp_pkg for field widths.
interface wsp_tick_if;
    logic valid;
    logic ready;
    logic right_edge;
    logic left_edge;
    logic rear_edge;
    logic report;

    modport source (output valid, right_edge, left_edge, rear_edge, report, input ready);
    modport sink   (input valid, right_edge, left_edge, rear_edge, report, output ready);
endinterface

interface wsp_speed_if;
    import wsp_pkg::*;
    logic             valid;
    logic             ready;
    logic [SPD_W-1:0] right_speed;
    logic [SPD_W-1:0] left_speed;
    logic [SPD_W-1:0] front_speed;
    logic [SPD_W-1:0] rear_speed;
    logic             histories_cleared;

    modport source (output valid, right_speed, left_speed, front_speed, rear_speed,
                    histories_cleared, input ready);
    modport sink   (input valid, right_speed, left_speed, front_speed, rear_speed,
                    histories_cleared, output ready);
endinterface

// ===== sv/wheel_speed_period_meter.sv =====
// Top level of the wheel speed period meter: config registers, controller
// and datapath. Depends on wsp_pkg, wsp_if, wsp_regs, wsp_ctrl, wsp_datapath.
//
//  Channel   Dir  Handshake             Carries
//  i_tick    in   valid/ready           right/left/rear edge flags, report
//  o_speed   out  valid/ready           right/left/front/rear speed, cleared flag
//  APB       in   psel/penable/pready   five configuration registers at 4*i
//
// A tick without report is taken in the idle state. A report tick runs three
// passes of multiply, load, 16 restoring-divider steps and store on the one
// shared divider, then the result register load. The result register is
// separate, so ticks are taken while a result waits; a second report waits at
// its end until the first result is taken. Reset is synchronous and active
// low, restores register defaults and clears counters and windows at once.
module wheel_speed_period_meter #(
    parameter int WINDOW = wsp_pkg::WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    wsp_tick_if.sink                    i_tick,
    wsp_speed_if.source                 o_speed,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wsp_pkg::PADDR_W-1:0] paddr,
    input  logic [wsp_pkg::PDATA_W-1:0] pwdata,
    output logic [wsp_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import wsp_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_tick.ready = w_in_ready;

    wsp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    wsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tick.valid),
        .i_report   (i_tick.report),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    wsp_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_right_edge (i_tick.right_edge),
        .i_left_edge  (i_tick.left_edge),
        .i_rear_edge  (i_tick.rear_edge),
        .o_speed      (o_speed)
    );

endmodule

// ===== sv/wsp_regs.sv =====
// APB-style configuration registers of the wheel speed period meter.
// Depends on wsp_pkg for register indexes, reset values and t_cfg.
module wsp_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wsp_pkg::PADDR_W-1:0]     paddr,
    input  logic [wsp_pkg::PDATA_W-1:0]     pwdata,
    output logic [wsp_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    output wsp_pkg::t_cfg                   o_cfg
);
    import wsp_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] w_idx;

    assign w_idx  = paddr[PADDR_W-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.front_tpr     <= RST_FRONT_TPR;
            r_cfg.rear_tpr      <= RST_REAR_TPR;
            r_cfg.speed_scale   <= RST_SCALE;
            r_cfg.speed_limit   <= RST_LIMIT;
            r_cfg.stall_timeout <= RST_TIMEOUT;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_FRONT_TPR: r_cfg.front_tpr     <= pwdata[TPR_W-1:0];
                REG_REAR_TPR:  r_cfg.rear_tpr      <= pwdata[TPR_W-1:0];
                REG_SCALE:     r_cfg.speed_scale   <= pwdata[SCALE_W-1:0];
                REG_LIMIT:     r_cfg.speed_limit   <= pwdata[SPD_W-1:0];
                REG_TIMEOUT:   r_cfg.stall_timeout <= pwdata[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_FRONT_TPR: prdata = PDATA_W'(r_cfg.front_tpr);
            REG_REAR_TPR:  prdata = PDATA_W'(r_cfg.rear_tpr);
            REG_SCALE:     prdata = PDATA_W'(r_cfg.speed_scale);
            REG_LIMIT:     prdata = PDATA_W'(r_cfg.speed_limit);
            REG_TIMEOUT:   prdata = PDATA_W'(r_cfg.stall_timeout);
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== sv/wsp_datapath.sv =====
// Datapath: period counters, period windows with running sums, shared
// restoring divider and the result register. Depends on wsp_pkg, wsp_if.
module wsp_datapath #(
    parameter int WINDOW = wsp_pkg::WINDOW_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wsp_pkg::t_cfg i_cfg,
    input  wsp_pkg::t_cmd i_cmd,
    output wsp_pkg::t_sts o_sts,
    input  logic          i_right_edge,
    input  logic          i_left_edge,
    input  logic          i_rear_edge,
    wsp_speed_if.source   o_speed
);
    import wsp_pkg::*;

    localparam int SUM_W  = CNT_W + $clog2(WINDOW);
    localparam int KMUL   = WINDOW * SPEED_UNITS;
    localparam int KMUL_W = $clog2(KMUL + 1);
    localparam int NUM_W  = SCALE_W + KMUL_W;
    localparam int DEN_W  = SUM_W + TPR_W;
    localparam int DIV_W  = DEN_W + SPD_W - 1;
    localparam int CMP_W  = DEN_W + SPD_W;

    logic [CNT_W-1:0]  r_cnt  [NUM_CH];
    logic [NUM_CH-1:0] r_run;
    logic [CNT_W-1:0]  r_hist [NUM_CH][WINDOW];
    logic [SUM_W-1:0]  r_sum  [NUM_CH];

    logic [CNT_W-1:0]  w_cnt_inc [NUM_CH];
    logic [CNT_W-1:0]  w_push    [NUM_CH];
    logic [NUM_CH-1:0] w_edge;
    logic              w_stall;

    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div;
    logic [SPD_W-1:0]  r_q;
    logic              r_ovf;
    logic              r_dz;
    logic [SUM_W-1:0]  w_sum_sel;
    logic [TPR_W-1:0]  w_tpr_sel;
    logic [CMP_W-1:0]  w_rem_ext;
    logic [CMP_W-1:0]  w_div_ext;
    logic [SPD_W-1:0]  w_speed;

    logic [SPD_W-1:0]  r_spd [NUM_CH];
    logic              r_out_valid;
    logic [SPD_W-1:0]  r_out_right;
    logic [SPD_W-1:0]  r_out_left;
    logic [SPD_W-1:0]  r_out_front;
    logic [SPD_W-1:0]  r_out_rear;
    logic              r_out_cleared;

    assign w_edge = {i_rear_edge, i_left_edge, i_right_edge};

    // A stopped counter reads zero and so never stalls.
    assign w_stall = (r_cnt[CH_RIGHT] > CNT_W'(i_cfg.stall_timeout)) &&
                     (r_cnt[CH_LEFT]  > CNT_W'(i_cfg.stall_timeout));

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_cnt_inc[c] = (r_run[c] && r_cnt[c] != '1) ? r_cnt[c] + CNT_W'(1) : r_cnt[c];
            w_push[c]    = r_run[c] ? w_cnt_inc[c] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_cnt[c] <= '0;
                r_sum[c] <= '0;
                for (int i = 0; i < WINDOW; i++) begin
                    r_hist[c][i] <= '0;
                end
            end
        end else begin
            if (i_cmd.tick_en) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    if (w_edge[c]) begin
                        for (int i = 0; i < WINDOW - 1; i++) begin
                            r_hist[c][i] <= r_hist[c][i+1];
                        end
                        r_hist[c][WINDOW-1] <= w_push[c];
                        r_sum[c] <= r_sum[c] - SUM_W'(r_hist[c][0]) + SUM_W'(w_push[c]);
                        r_cnt[c] <= '0;
                        r_run[c] <= 1'b1;
                    end else begin
                        r_cnt[c] <= w_cnt_inc[c];
                    end
                end
            end
            if (i_cmd.finish && w_stall) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_sum[c] <= '0;
                    for (int i = 0; i < WINDOW; i++) begin
                        r_hist[c][i] <= '0;
                    end
                end
            end
        end
    end

    always_comb begin
        case (i_cmd.chan)
            CH_RIGHT: begin
                w_sum_sel = r_sum[CH_RIGHT];
                w_tpr_sel = i_cfg.front_tpr;
            end
            CH_LEFT: begin
                w_sum_sel = r_sum[CH_LEFT];
                w_tpr_sel = i_cfg.front_tpr;
            end
            CH_REAR: begin
                w_sum_sel = r_sum[CH_REAR];
                w_tpr_sel = i_cfg.rear_tpr;
            end
            default: begin
                w_sum_sel = '0;
                w_tpr_sel = '0;
            end
        endcase
    end

    assign w_rem_ext = CMP_W'(r_rem);
    assign w_div_ext = CMP_W'(r_div);

    // Zero on empty window or zero tpr, quotient above 16 bits, or exact ratio above the limit.
    assign w_speed = (r_dz || r_ovf || r_q > i_cfg.speed_limit ||
                      (r_q == i_cfg.speed_limit && r_rem != '0)) ? '0 : r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_num <= NUM_W'(i_cfg.speed_scale) * NUM_W'(KMUL);
            r_den <= DEN_W'(w_sum_sel) * DEN_W'(w_tpr_sel);
        end
        if (i_cmd.load_en) begin
            r_rem <= r_num;
            r_div <= DIV_W'(r_den) << (SPD_W - 1);
            r_q   <= '0;
            r_ovf <= CMP_W'(r_num) >= (CMP_W'(r_den) << SPD_W);
            r_dz  <= (r_den == '0);
        end
        if (i_cmd.step_en) begin
            if (w_rem_ext >= w_div_ext) begin
                r_rem <= NUM_W'(w_rem_ext - w_div_ext);
                r_q   <= {r_q[SPD_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[SPD_W-2:0], 1'b0};
            end
            r_div <= r_div >> 1;
        end
        if (i_cmd.store_en) begin
            case (i_cmd.chan)
                CH_RIGHT: r_spd[CH_RIGHT] <= w_speed;
                CH_LEFT:  r_spd[CH_LEFT]  <= w_speed;
                CH_REAR:  r_spd[CH_REAR]  <= w_speed;
                default: ;
            endcase
        end
        if (i_cmd.finish) begin
            r_out_right   <= r_spd[CH_RIGHT];
            r_out_left    <= r_spd[CH_LEFT];
            r_out_front   <= (r_spd[CH_RIGHT] > r_spd[CH_LEFT]) ?
                             r_spd[CH_RIGHT] : r_spd[CH_LEFT];
            r_out_rear    <= r_spd[CH_REAR];
            r_out_cleared <= w_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_speed.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free            = !r_out_valid || o_speed.ready;
    assign o_speed.valid             = r_out_valid;
    assign o_speed.right_speed       = r_out_right;
    assign o_speed.left_speed        = r_out_left;
    assign o_speed.front_speed       = r_out_front;
    assign o_speed.rear_speed        = r_out_rear;
    assign o_speed.histories_cleared = r_out_cleared;

    a_finish_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("result register not loaded after finish");

    a_stall_clears_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && w_stall) |=>
            (r_sum[CH_RIGHT] == '0 && r_sum[CH_LEFT] == '0 && r_sum[CH_REAR] == '0))
        else $error("period sums not cleared on stall");

endmodule

// ===== sv/wsp_ctrl.sv =====
// Controller: accepts ticks, sequences the shared divider over the three
// wheels on a report and hands the result over. Depends on wsp_pkg.
module wsp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_report,
    output logic          o_in_ready,
    input  wsp_pkg::t_sts i_sts,
    output wsp_pkg::t_cmd o_cmd
);
    import wsp_pkg::*;

    t_state            r_state, n_state;
    t_chan             r_chan, n_chan;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chan  <= CH_RIGHT;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_chan     = r_chan;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.chan = r_chan;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.tick_en = i_in_valid;
                if (i_in_valid && i_report) begin
                    n_chan  = CH_RIGHT;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_en = 1'b1;
                n_step        = STEP_W'(SPD_W - 1);
                n_state       = S_DIV;
            end
            S_DIV: begin
                o_cmd.step_en = 1'b1;
                if (r_step == '0) begin
                    n_state = S_STORE;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            S_STORE: begin
                o_cmd.store_en = 1'b1;
                case (r_chan)
                    CH_RIGHT: begin
                        n_chan  = CH_LEFT;
                        n_state = S_MUL;
                    end
                    CH_LEFT: begin
                        n_chan  = CH_REAR;
                        n_state = S_MUL;
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_FINISH: begin
                // hold until the result register can take the new result
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == '0) |=> r_state == S_STORE)
        else $error("divider did not end after last step");

    a_rear_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STORE && r_chan == CH_REAR) |=> r_state == S_FINISH)
        else $error("report did not finish after rear wheel");

endmodule

// ===== test/wsp_speed_checker.sv =====
// Checker for the wheel speed period meter: watches the tick, speed and APB
// channels, predicts each speed report and compares it field by field.
// Depends on wsp_pkg and the channel interfaces in wsp_if.
module wsp_speed_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    wsp_tick_if                         tick_mon,
    wsp_speed_if                        speed_mon,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [wsp_pkg::PADDR_W-1:0] paddr,
    input  logic [wsp_pkg::PDATA_W-1:0] pwdata,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_cleared,
    output int                          o_moving
);
    timeunit 1ns;
    timeprecision 1ps;

    import wsp_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [SPD_W-1:0] right_spd;
        logic [SPD_W-1:0] left_spd;
        logic [SPD_W-1:0] front_spd;
        logic [SPD_W-1:0] rear_spd;
        logic             cleared;
    } t_speeds;

    t_cfg              cfg;
    logic [CNT_W-1:0]  elapsed [NUM_CH];
    logic [NUM_CH-1:0] running;
    logic [CNT_W-1:0]  history [NUM_CH][WINDOW_DEF];
    t_speeds           speed_q[$];

    int errors  = 0;
    int checked = 0;
    int cleared = 0;
    int moving  = 0;
    int pending = 0;

    assign o_errors  = errors;
    assign o_pending = pending;
    assign o_checked = checked;
    assign o_cleared = cleared;
    assign o_moving  = moving;

    task automatic report_mismatch(input string field, input longint got, input longint want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("%0t ns: speed report %0d, %s: got %0d, expected %0d",
                     $time, checked, field, got, want);
    endtask

    task automatic clear_model();
        cfg.front_tpr     = RST_FRONT_TPR;
        cfg.rear_tpr      = RST_REAR_TPR;
        cfg.speed_scale   = RST_SCALE;
        cfg.speed_limit   = RST_LIMIT;
        cfg.stall_timeout = RST_TIMEOUT;
        running = '0;
        foreach (elapsed[c]) elapsed[c] = '0;
        foreach (history[c, i]) history[c][i] = '0;
        speed_q.delete();
    endtask

    task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        case (addr[PADDR_W-1:2])
            REG_FRONT_TPR: cfg.front_tpr     = data[TPR_W-1:0];
            REG_REAR_TPR:  cfg.rear_tpr      = data[TPR_W-1:0];
            REG_SCALE:     cfg.speed_scale   = data[SCALE_W-1:0];
            REG_LIMIT:     cfg.speed_limit   = data[SPD_W-1:0];
            REG_TIMEOUT:   cfg.stall_timeout = data[TMO_W-1:0];
            default: ;
        endcase
    endtask

    // Advance a running counter, then on a pulse shift its count into the window.
    task automatic step_channel(input t_chan ch, input logic pulse);
        if (running[ch] && elapsed[ch] != '1)
            elapsed[ch] = elapsed[ch] + 1'b1;
        if (pulse) begin
            for (int i = 0; i < WINDOW_DEF - 1; i++)
                history[ch][i] = history[ch][i + 1];
            history[ch][WINDOW_DEF-1] = running[ch] ? elapsed[ch] : '0;
            elapsed[ch] = '0;
            running[ch] = 1'b1;
        end
    endtask

    function automatic logic [SPD_W-1:0] wheel_speed(input t_chan ch, input logic [TPR_W-1:0] tpr);
        logic [63:0] total;
        logic [63:0] den;
        logic [63:0] num;
        total = '0;
        for (int i = 0; i < WINDOW_DEF; i++)
            total += 64'(history[ch][i]);
        den = total * 64'(tpr);
        if (den == 0)
            return '0;
        num = 64'(cfg.speed_scale) * 64'(WINDOW_DEF) * 64'(SPEED_UNITS);
        // the exact quotient above the limit reads as zero
        if (num > 64'(cfg.speed_limit) * den)
            return '0;
        return SPD_W'(num / den);
    endfunction

    task automatic take_tick(input logic r, input logic l, input logic b, input logic rep);
        t_speeds want;
        step_channel(CH_RIGHT, r);
        step_channel(CH_LEFT, l);
        step_channel(CH_REAR, b);
        if (rep) begin
            want.right_spd = wheel_speed(CH_RIGHT, cfg.front_tpr);
            want.left_spd  = wheel_speed(CH_LEFT, cfg.front_tpr);
            want.rear_spd  = wheel_speed(CH_REAR, cfg.rear_tpr);
            want.front_spd = (want.right_spd > want.left_spd) ? want.right_spd : want.left_spd;
            want.cleared   = 1'b0;
            // stall check runs after the speeds are formed; counters keep going
            if (elapsed[CH_RIGHT] > 32'(cfg.stall_timeout) &&
                elapsed[CH_LEFT] > 32'(cfg.stall_timeout)) begin
                foreach (history[c, i]) history[c][i] = '0;
                want.cleared = 1'b1;
                cleared++;
            end
            if (want.front_spd != 0 || want.rear_spd != 0)
                moving++;
            speed_q.push_back(want);
        end
    endtask

    task automatic check_report();
        t_speeds want;
        if (speed_q.size() == 0) begin
            report_mismatch("report with nothing expected", 1, 0);
            return;
        end
        want = speed_q.pop_front();
        checked++;
        if (speed_mon.right_speed !== want.right_spd)
            report_mismatch("right_speed", speed_mon.right_speed, want.right_spd);
        if (speed_mon.left_speed !== want.left_spd)
            report_mismatch("left_speed", speed_mon.left_speed, want.left_spd);
        if (speed_mon.front_speed !== want.front_spd)
            report_mismatch("front_speed", speed_mon.front_speed, want.front_spd);
        if (speed_mon.rear_speed !== want.rear_spd)
            report_mismatch("rear_speed", speed_mon.rear_speed, want.rear_spd);
        if (speed_mon.histories_cleared !== want.cleared)
            report_mismatch("histories_cleared", speed_mon.histories_cleared, want.cleared);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (psel && penable && pwrite && pready)
                write_register(paddr, pwdata);
            if (tick_mon.valid && tick_mon.ready)
                take_tick(tick_mon.right_edge, tick_mon.left_edge, tick_mon.rear_edge,
                          tick_mon.report);
            if (speed_mon.valid && speed_mon.ready)
                check_report();
        end
        pending = speed_q.size();
    end

endmodule

// ===== test/tb_wheel_speed_period_meter.sv =====
// Top of the wheel speed period meter testbench: clock, reset, APB setup,
// sensor tick traffic and result back-pressure, and the final verdict.
// Depends on wsp_pkg, wsp_if, the block and wsp_speed_checker.
module tb_wheel_speed_period_meter;
    timeunit 1ns;
    timeprecision 1ps;

    import wsp_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RST_CYCLES     = 12;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int MAX_WAIT       = 17;
    localparam int SETTLE_CYCLES  = 70;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_TICKS    = 158;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int errors;
    int pending;
    int checked;
    int cleared;
    int moving;
    int cycles   = 0;
    int sent     = 0;
    int settings = 1;
    int rx_hold  = 0;
    bit no_idle  = 1'b0;

    wsp_tick_if  tick_ch ();
    wsp_speed_if speed_ch ();

    wheel_speed_period_meter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_ch),
        .o_speed (speed_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    wsp_speed_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .tick_mon  (tick_ch),
        .speed_mon (speed_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked),
        .o_cleared (cleared),
        .o_moving  (moving)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("run stopped at the cycle limit, %0d reports still owed", pending);
            $display("tb_wheel_speed_period_meter: errors");
            $finish;
        end
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Result side: stall for a drawn wait or a pending hold, then take one transaction.
    initial begin
        int stall;
        speed_ch.ready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = (rx_hold > 0) ? rx_hold : draw_wait();
            rx_hold = 0;
            if (stall > 0) begin
                speed_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            speed_ch.ready <= 1'b1;
            @(negedge i_clk);
            while (!speed_ch.valid && rx_hold == 0) @(negedge i_clk);
            @(posedge i_clk);
        end
    end

    task automatic send_tick(input logic r, input logic l, input logic b, input logic rep);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.right_edge <= r;
        tick_ch.left_edge  <= l;
        tick_ch.rear_edge  <= b;
        tick_ch.report     <= rep;
        @(negedge i_clk);
        while (!tick_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
        sent++;
    endtask

    // Hold the tick side until every report is back, then let the block settle.
    task automatic drain_reports();
        tick_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_config(input int ftpr, input int rtpr, input int scale,
                                input int limit, input int timeout);
        write_reg(REG_FRONT_TPR, PDATA_W'(ftpr));
        write_reg(REG_REAR_TPR, PDATA_W'(rtpr));
        write_reg(REG_SCALE, PDATA_W'(scale));
        write_reg(REG_LIMIT, PDATA_W'(limit));
        write_reg(REG_TIMEOUT, PDATA_W'(timeout));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        settings++;
    endtask

    // Wheels turn at steady periods per segment; some segments stop the
    // front wheels to force stalls, and a share of ticks is pure noise.
    task automatic run_traffic(input int n_ticks);
        int   period    [NUM_CH];
        int   countdown [NUM_CH];
        logic pulse     [NUM_CH];
        logic rep;
        int   seg_left;
        seg_left = 0;
        for (int k = 0; k < n_ticks; k++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 60);
                no_idle  = ($urandom_range(0, 3) == 0);
                for (int c = 0; c < NUM_CH; c++) begin
                    period[c]    = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 30);
                    countdown[c] = $urandom_range(1, 4);
                end
                if ($urandom_range(0, 4) == 0) begin
                    period[CH_RIGHT] = 0;
                    period[CH_LEFT]  = 0;
                end
            end
            seg_left--;
            for (int c = 0; c < NUM_CH; c++) begin
                pulse[c] = 1'b0;
                if (period[c] != 0) begin
                    countdown[c]--;
                    if (countdown[c] <= 0) begin
                        pulse[c]     = 1'b1;
                        countdown[c] = period[c] + $urandom_range(0, 2);
                    end
                end
            end
            rep = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0) begin
                for (int c = 0; c < NUM_CH; c++)
                    pulse[c] = 1'($urandom_range(0, 1));
                rep = 1'($urandom_range(0, 1));
            end
            send_tick(pulse[CH_RIGHT], pulse[CH_LEFT], pulse[CH_REAR], rep);
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.right_edge = 1'b0;
        tick_ch.left_edge  = 1'b0;
        tick_ch.rear_edge  = 1'b0;
        tick_ch.report     = 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty windows, first edges push zero, over-limit speeds
        send_tick(1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0, 1'b1);

        for (int p = 1; p <= NUM_PHASES; p++) begin
            drain_reports();
            case (p)
                1: write_config(255, 255, 100, 65535, 0);
                2: write_config(1, 1, 65535, 65535, 16777215);
                3: write_config(255, 0, 50, 9000, 7);
                4: write_config(170, 85, 0, 0, 25);
                default: write_config($urandom_range(1, 255), $urandom_range(1, 255),
                                      $urandom_range(0, 3000), $urandom_range(0, 65535),
                                      $urandom_range(0, 40));
            endcase
            if (p == 1) begin
                // zero timeout: clear on a lasting stall, then single-wheel windows
                send_tick(1'b0, 1'b0, 1'b0, 1'b1);
                send_tick(1'b0, 1'b0, 1'b0, 1'b1);
                send_tick(1'b1, 1'b0, 1'b0, 1'b1);
                send_tick(1'b0, 1'b1, 1'b0, 1'b1);
                send_tick(1'b0, 1'b0, 1'b1, 1'b1);
                send_tick(1'b1, 1'b1, 1'b1, 1'b1);
                send_tick(1'b1, 1'b1, 1'b0, 1'b0);
                send_tick(1'b1, 1'b0, 1'b1, 1'b1);
                send_tick(1'b0, 1'b1, 1'b1, 1'b1);
            end
            if (p == 3)
                rx_hold = HOLDOFF_CYCLES;
            run_traffic(PHASE_TICKS);
        end

        drain_reports();
        $display("%0d ticks over %0d register settings, %0d speed reports checked",
                 sent, settings, checked);
        $display("%0d reports cleared the windows, %0d carried a nonzero speed",
                 cleared, moving);
        if (errors == 0)
            $display("tb_wheel_speed_period_meter: clean");
        else
            $display("tb_wheel_speed_period_meter: errors");
        $finish;
    end

endmodule
